// ===== sv/mpe_pkg.sv =====
// Shared types and constants for the Mandelbrot pixel escape-time unit.
// Depends on nothing; every other file imports it.
package mpe_pkg;

  localparam int unsigned FRAC_BITS     = 28;
  localparam int unsigned MAX_IMAGE_DIM = 4096;
  localparam int unsigned ITER_WIDTH    = 16;
  localparam int unsigned PIX_W         = 12;
  localparam int unsigned COORD_W       = 32;
  localparam int unsigned STEP_W        = 31;
  localparam int unsigned ROWS_W        = 13;
  localparam int unsigned ROWOFF_W      = 14;
  localparam int unsigned PROD_W        = 64;
  localparam int unsigned COLOUR_W      = 8;
  localparam int unsigned CFG_IDX_W     = 3;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]      out_x;
    logic [PIX_W-1:0]      out_y;
    logic [ITER_WIDTH-1:0] iterations;
    logic                  escaped;
    logic [COLOUR_W-1:0]   colour_index;
  } result_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_MIN    = 3'd0,
    CFG_Y_MIN    = 3'd1,
    CFG_STEP_X   = 3'd2,
    CFG_STEP_Y   = 3'd3,
    CFG_ROWS     = 3'd4,
    CFG_MAX_ITER = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    SQR_COORD = 1'b0,
    SQR_Z     = 1'b1
  } sqr_mode_e;

  typedef struct packed {
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] ri;
  } prod_t;

  typedef struct packed {
    logic                  start;
    logic [ITER_WIDTH-1:0] iter;
    logic [ITER_WIDTH-1:0] limit;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [COLOUR_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== sv/mpe_sqr.sv =====
// Shared multiplier bank: three signed 32x32 products, registered.
// Squares z (rr, ii, ri) or scales the pixel coordinates. Depends on mpe_pkg.
module mpe_sqr (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  mpe_pkg::sqr_mode_e                  mode_i,
  input  logic signed [mpe_pkg::COORD_W-1:0]  zr_i,
  input  logic signed [mpe_pkg::COORD_W-1:0]  zi_i,
  input  logic [mpe_pkg::PIX_W-1:0]           px_i,
  input  logic signed [mpe_pkg::ROWOFF_W-1:0] row_off_i,
  input  logic [mpe_pkg::STEP_W-1:0]          step_x_i,
  input  logic [mpe_pkg::STEP_W-1:0]          step_y_i,
  output mpe_pkg::prod_t                      prod_o
);
  import mpe_pkg::*;

  logic signed [COORD_W-1:0] a0, b0, a1, b1, a2, b2;
  logic signed [PROD_W-1:0]  m0, m1, m2;
  prod_t                     prod_q;

  always_comb begin
    unique case (mode_i)
      SQR_Z: begin
        a0 = zr_i;
        b0 = zr_i;
        a1 = zi_i;
        b1 = zi_i;
        a2 = zr_i;
        b2 = zi_i;
      end
      SQR_COORD: begin
        a0 = signed'({{(COORD_W-PIX_W){1'b0}}, px_i});
        b0 = signed'({{(COORD_W-STEP_W){1'b0}}, step_x_i});
        a1 = signed'({{(COORD_W-ROWOFF_W){row_off_i[ROWOFF_W-1]}}, row_off_i});
        b1 = signed'({{(COORD_W-STEP_W){1'b0}}, step_y_i});
        a2 = '0;
        b2 = '0;
      end
      default: begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
        a2 = '0;
        b2 = '0;
      end
    endcase
  end

  assign m0 = PROD_W'(a0) * PROD_W'(b0);
  assign m1 = PROD_W'(a1) * PROD_W'(b1);
  assign m2 = PROD_W'(a2) * PROD_W'(b2);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q.rr <= m0;
      prod_q.ii <= m1;
      prod_q.ri <= m2;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== sv/mpe_div.sv =====
// Radix-2 restoring divider for the palette index: floor(iter*255/limit).
// One quotient bit per cycle. Depends on mpe_pkg.
module mpe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpe_pkg::div_req_t req_i,
  output mpe_pkg::div_rsp_t rsp_o
);
  import mpe_pkg::*;

  localparam int unsigned NUM_W = ITER_WIDTH + COLOUR_W;
  localparam int unsigned CNT_W = $clog2(COLOUR_W);

  logic [NUM_W-1:0]      num;
  logic [ITER_WIDTH-1:0] rem_q, div_q;
  logic [COLOUR_W-1:0]   lo_q, quot_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q, done_q;
  logic [ITER_WIDTH:0]   trial, diff;
  logic                  ge;

  // iter*255 as (iter << 8) - iter; the quotient then fits in 8 bits
  assign num   = {req_i.iter, {COLOUR_W{1'b0}}} - NUM_W'(req_i.iter);
  assign trial = {rem_q, lo_q[COLOUR_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(COLOUR_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= num[NUM_W-1:COLOUR_W];
      lo_q  <= num[COLOUR_W-1:0];
      div_q <= req_i.limit;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[ITER_WIDTH-1:0] : trial[ITER_WIDTH-1:0];
      lo_q   <= {lo_q[COLOUR_W-2:0], 1'b0};
      quot_q <= {quot_q[COLOUR_W-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ===== sv/mandelbrot_pixel_escape_time_unit.sv =====
// Per item: ST_MAP and ST_CADD form c, then ST_MUL and ST_ADD repeat once per z update
//   (multiply in the shared multiplier bank, then shift/add/test) until the point escapes
//   or the iteration limit is hit; ST_DIV waits for the palette divider to finish, and
//   ST_OUT waits for a free output register. The unit holds one item at a time; the next
//   item is taken in the cycle after the result is loaded into the output register.
// Reset: rst_ni clears control state and loads the default plane region.
module mandelbrot_pixel_escape_time_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [mpe_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mpe_pkg::COORD_W-1:0]       cfg_wdata_i,
  // pixel input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mpe_pkg::pixel_in_t                in_data_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mpe_pkg::result_t                  out_data_o
);
  import mpe_pkg::*;

  // Reset values of the plane region registers (Q4.28)
  localparam logic signed [COORD_W-1:0] X_MIN_RST    = 32'hE000_0000;  // -2.0
  localparam logic signed [COORD_W-1:0] Y_MIN_RST    = 32'hF000_0000;  // -1.0
  localparam logic [STEP_W-1:0]         STEP_RST     = 31'd262144;     // 2^-10
  localparam logic [ROWS_W-1:0]         ROWS_RST     = 13'd1024;
  localparam logic [ITER_WIDTH-1:0]     MAX_ITER_RST = 16'd256;

  localparam logic [PIX_W-1:0] PIX_MAX = PIX_W'(MAX_IMAGE_DIM - 1);

  // Escape threshold |z|^2 > 4, in the squared fraction format
  localparam int unsigned      ESC_SHIFT = 2 * FRAC_BITS + 2;
  localparam bit               ESC_ON    = (ESC_SHIFT < PROD_W);
  localparam logic [PROD_W-1:0] ESC_LIM  = ESC_ON ? (PROD_W'(1) << ESC_SHIFT) : '0;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b000_0001,
    ST_MAP  = 7'b000_0010,  // coordinate products in the multiplier bank
    ST_CADD = 7'b000_0100,  // c = min + product, saturated
    ST_MUL  = 7'b000_1000,  // z squared products
    ST_ADD  = 7'b001_0000,  // escape test, z update
    ST_DIV  = 7'b010_0000,  // palette index division
    ST_OUT  = 7'b100_0000
  } state_e;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi, lo;
    hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
    lo = -hi - PROD_W'(1);
    if (v > hi)      sat32 = {1'b0, {(COORD_W-1){1'b1}}};
    else if (v < lo) sat32 = {1'b1, {(COORD_W-1){1'b0}}};
    else             sat32 = v[COORD_W-1:0];
  endfunction

  state_e state_q, state_d;

  // configuration registers
  logic signed [COORD_W-1:0] x_min_q, y_min_q;
  logic [STEP_W-1:0]         step_x_q, step_y_q;
  logic [ROWS_W-1:0]         rows_q;
  logic [ITER_WIDTH-1:0]     max_iter_q;

  // per-item working registers
  logic [PIX_W-1:0]           px_raw_q, py_raw_q, px_q;
  logic signed [ROWOFF_W-1:0] row_off_q;
  logic signed [COORD_W-1:0]  cr_q, ci_q, zr_q, zi_q;
  logic [ITER_WIDTH-1:0]      iter_q;
  logic                       stepped_q, esc_q;

  logic     out_valid_q;
  result_t  out_data_q;

  // shared multiplier bank
  sqr_mode_e sqr_mode;
  logic      sqr_en;
  prod_t     prod;

  // divider
  div_req_t div_req;
  div_rsp_t div_rsp;

  // item accept and clamped pixel
  logic                  in_fire;
  logic [PIX_W-1:0]      px_clamp, py_clamp;
  logic [ROWOFF_W-1:0]   row_off_new;

  // step datapath
  logic signed [PROD_W-1:0] sum_cr, sum_ci, diff_rr_ii, sum_nr, sum_ni;
  logic signed [COORD_W-1:0] nr, ni;
  logic [PROD_W-1:0]         mag;
  logic                      esc_now, limit_hit, finish, out_load;
  logic [ITER_WIDTH-1:0]     iter_next, iter_fin;

  // ---------------------------------------------------------------------------
  // Configuration writes; indices past the list are ignored
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= X_MIN_RST;
      y_min_q    <= Y_MIN_RST;
      step_x_q   <= STEP_RST;
      step_y_q   <= STEP_RST;
      rows_q     <= ROWS_RST;
      max_iter_q <= MAX_ITER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_X_MIN:    x_min_q    <= signed'(cfg_wdata_i);
        CFG_Y_MIN:    y_min_q    <= signed'(cfg_wdata_i);
        CFG_STEP_X:   step_x_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_STEP_Y:   step_y_q   <= cfg_wdata_i[STEP_W-1:0];
        CFG_ROWS:     rows_q     <= cfg_wdata_i[ROWS_W-1:0];
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: clamp to the image limit, flip the row (may go negative)
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  assign px_clamp = (in_data_i.pixel_x > PIX_MAX) ? PIX_MAX : in_data_i.pixel_x;
  assign py_clamp = (in_data_i.pixel_y > PIX_MAX) ? PIX_MAX : in_data_i.pixel_y;
  // wraps mod 2^14; the true value always fits the signed 14-bit range
  assign row_off_new = ROWOFF_W'(rows_q) - ROWOFF_W'(1) - ROWOFF_W'(py_clamp);

  // ---------------------------------------------------------------------------
  // Multiplier bank: coordinate scaling in ST_MAP, z squaring in ST_MUL
  // ---------------------------------------------------------------------------
  assign sqr_mode = (state_q == ST_MAP) ? SQR_COORD : SQR_Z;
  assign sqr_en   = (state_q == ST_MAP) || (state_q == ST_MUL);

  mpe_sqr u_sqr (
    .clk_i     (clk_i),
    .en_i      (sqr_en),
    .mode_i    (sqr_mode),
    .zr_i      (zr_q),
    .zi_i      (zi_q),
    .px_i      (px_q),
    .row_off_i (row_off_q),
    .step_x_i  (step_x_q),
    .step_y_i  (step_y_q),
    .prod_o    (prod)
  );

  // c from the coordinate products
  assign sum_cr = PROD_W'(x_min_q) + prod.rr;
  assign sum_ci = PROD_W'(y_min_q) + prod.ii;

  // z*z + c: the arithmetic shifts floor toward minus infinity;
  // ri is shifted one less to get 2*re*im
  assign diff_rr_ii = prod.rr - prod.ii;
  assign sum_nr     = (diff_rr_ii >>> FRAC_BITS) + PROD_W'(cr_q);
  assign sum_ni     = (prod.ri >>> (FRAC_BITS - 1)) + PROD_W'(ci_q);
  assign nr         = sat32(sum_nr);
  assign ni         = sat32(sum_ni);

  // |z|^2 of the current z; squares of saturated values stay below 2^63
  assign mag       = unsigned'(prod.rr) + unsigned'(prod.ii);
  assign esc_now   = stepped_q && ESC_ON && (mag > ESC_LIM);
  assign iter_next = iter_q + ITER_WIDTH'(stepped_q);
  assign limit_hit = (iter_next == max_iter_q);
  assign finish    = esc_now || limit_hit;
  // an escaping step does not count
  assign iter_fin  = esc_now ? iter_q : iter_next;

  // ---------------------------------------------------------------------------
  // Palette index divider, started on the final test cycle
  // ---------------------------------------------------------------------------
  assign div_req.start = (state_q == ST_ADD) && finish;
  assign div_req.iter  = iter_fin;
  assign div_req.limit = max_iter_q;

  mpe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_MAP;
      ST_MAP:  state_d = ST_CADD;
      ST_CADD: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = finish ? ST_DIV : ST_MUL;
      ST_DIV:  if (div_rsp.done) state_d = ST_OUT;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      px_raw_q  <= in_data_i.pixel_x;
      py_raw_q  <= in_data_i.pixel_y;
      px_q      <= px_clamp;
      row_off_q <= signed'(row_off_new);
    end
    if (state_q == ST_CADD) begin
      cr_q      <= sat32(sum_cr);
      ci_q      <= sat32(sum_ci);
      zr_q      <= '0;
      zi_q      <= '0;
      iter_q    <= '0;
      stepped_q <= 1'b0;
      esc_q     <= 1'b0;
    end
    if (state_q == ST_ADD) begin
      if (finish) begin
        iter_q <= iter_fin;
        esc_q  <= esc_now;
      end else begin
        zr_q      <= nr;
        zi_q      <= ni;
        iter_q    <= iter_next;
        stepped_q <= 1'b1;
      end
    end
    if (out_load) begin
      out_data_q.out_x        <= px_raw_q;
      out_data_q.out_y        <= py_raw_q;
      out_data_q.iterations   <= iter_q;
      out_data_q.escaped      <= esc_q;
      out_data_q.colour_index <= (max_iter_q == '0) ? '0 : div_rsp.quot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // an escaping point always stops short of the limit
  a_esc_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.escaped |-> out_data_o.iterations < max_iter_q)
    else $error("escaped item reached the iteration limit");

  // a point that never escapes ran the full limit
  a_bound_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.escaped |-> out_data_o.iterations == max_iter_q)
    else $error("bounded item stopped before the limit");

  // full limit maps to the top palette entry
  a_colour_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.escaped && (max_iter_q != '0)
      |-> out_data_o.colour_index == {COLOUR_W{1'b1}})
    else $error("palette index wrong at the limit");

  // the divider only runs while the sequencer waits for it
  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> state_q == ST_DIV)
    else $error("divider busy outside the division state");

endmodule

// ===== bench/mandelbrot_pixel_escape_time_unit_tb.sv =====
// Self-checking bench for the Mandelbrot pixel escape-time unit: directed plane and
// limit corners, then random planes and pixels under four idling patterns.
// Depends on mpe_pkg and mandelbrot_pixel_escape_time_unit only.
module mandelbrot_pixel_escape_time_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mpe_pkg::*;

  // Q4.28 handy values
  localparam logic [31:0] Q_ONE    = 32'h1000_0000;
  localparam logic [31:0] Q_NEG2   = 32'hE000_0000;
  localparam logic [31:0] Q_NEG1   = 32'hF000_0000;
  localparam logic [31:0] S32_MAXV = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MINV = 32'h8000_0000;
  localparam longint      SAT_HI   = 64'sh7FFF_FFFF;
  localparam longint      SAT_LO   = -64'sh8000_0000;
  localparam int          RAND_MODES    = 4;
  localparam int          RAND_PLANES   = 8;
  localparam int          PIX_PER_PLANE = 61;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          MAX_PRINTS    = 40;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [2:0]       cfg_index_i = '0;
  logic [31:0]      cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  pixel_in_t        in_data_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  result_t          out_data_o;

  // Local copy of the plane registers, starting at the reset values.
  logic signed [31:0] x_min_q    = 32'shE000_0000;
  logic signed [31:0] y_min_q    = 32'shF000_0000;
  logic [30:0]        step_x_q   = 31'd262144;
  logic [30:0]        step_y_q   = 31'd262144;
  logic [12:0]        rows_q     = 13'd1024;
  logic [15:0]        max_iter_q = 16'd256;

  result_t pending_results[$];

  int     idle_pct = 0;      // sender: chance in 100 that a cycle is left empty
  int     stall_pct = 0;     // receiver: chance in 100 that ready is held low
  int     err_cnt = 0;
  int     accepted_cnt = 0;
  int     checked_cnt = 0;
  int     escaped_cnt = 0;
  int     capped_cnt = 0;
  int     plane_cnt = 0;
  longint cycle_cnt = 0;
  longint time_budget = 0;   // slowest legal cycles for what has been sent so far

  mandelbrot_pixel_escape_time_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor: escape-time of one pixel in Q4.28 with 64-bit products.
  // ---------------------------------------------------------------------------
  function automatic longint clip32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic result_t escape_time(input pixel_in_t pix);
    result_t           res;
    longint            px;
    longint            py;
    longint            row_off;
    longint            cr;
    longint            ci;
    longint            zr;
    longint            zi;
    longint            nr;
    longint            ni;
    longint unsigned   mag;
    longint unsigned   iter;
    longint unsigned   lim;
    longint unsigned   colour;
    bit                esc;
    px = longint'(pix.pixel_x);
    py = longint'(pix.pixel_y);
    // coordinates past the largest image are pinned to its last pixel
    if (px > MAX_IMAGE_DIM - 1) px = MAX_IMAGE_DIM - 1;
    if (py > MAX_IMAGE_DIM - 1) py = MAX_IMAGE_DIM - 1;
    lim = longint'(max_iter_q);
    // row zero is the top, so the imaginary axis counts up from the last row;
    // rows outside the image give a negative offset, used as is
    row_off = longint'(rows_q) - 1 - py;
    cr = clip32(longint'(x_min_q) + px * longint'(step_x_q));
    ci = clip32(longint'(y_min_q) + row_off * longint'(step_y_q));
    zr = 0;
    zi = 0;
    iter = 0;
    esc = 1'b0;
    while (iter < lim) begin
      // >>> on a signed longint floors, matching the hardware shift
      nr = clip32(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
      ni = clip32(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      // each square is at most 2^62, the sum needs the unsigned range
      mag = longint'(zr * zr);
      mag = mag + longint'(zi * zi);
      if (mag > (64'd1 << (2 * FRAC_BITS + 2))) begin
        esc = 1'b1;
        break;
      end
      iter++;
    end
    colour = (lim != 0) ? (iter * 255) / lim : 0;
    res.out_x        = pix.pixel_x;
    res.out_y        = pix.pixel_y;
    res.iterations   = iter[ITER_WIDTH-1:0];
    res.escaped      = esc;
    res.colour_index = colour[COLOUR_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard side
  // ---------------------------------------------------------------------------
  task automatic flag_error(input string what);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Every accepted pixel gets its expected result queued right at the handshake.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      pending_results.insert(pending_results.size(), escape_time(in_data_i));
      accepted_cnt++;
    end
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result for pixel (%0d,%0d)", got.out_x, got.out_y));
      end else begin
        want = pending_results.pop_front();
        checked_cnt++;
        if (want.escaped) escaped_cnt++;
        else capped_cnt++;
        if (got.out_x !== want.out_x)
          flag_error($sformatf("out_x got %0d want %0d", got.out_x, want.out_x));
        if (got.out_y !== want.out_y)
          flag_error($sformatf("out_y got %0d want %0d", got.out_y, want.out_y));
        if (got.iterations !== want.iterations)
          flag_error($sformatf("pixel (%0d,%0d) iterations got %0d want %0d",
                               want.out_x, want.out_y, got.iterations, want.iterations));
        if (got.escaped !== want.escaped)
          flag_error($sformatf("pixel (%0d,%0d) escaped got %0b want %0b",
                               want.out_x, want.out_y, got.escaped, want.escaped));
        if (got.colour_index !== want.colour_index)
          flag_error($sformatf("pixel (%0d,%0d) colour got %0d want %0d",
                               want.out_x, want.out_y, got.colour_index, want.colour_index));
      end
    end
  end

  // Hang guard: the budget grows with every item by its worst legal cost.
  initial begin
    while (cycle_cnt <= 4 * time_budget + 20000) @(posedge clk_i);
    $display("ERROR: timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, pending_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end on a rising edge.
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_X_MIN:    x_min_q    = val;
      CFG_Y_MIN:    y_min_q    = val;
      CFG_STEP_X:   step_x_q   = val[30:0];
      CFG_STEP_Y:   step_y_q   = val[30:0];
      CFG_ROWS:     rows_q     = val[12:0];
      CFG_MAX_ITER: max_iter_q = val[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_plane(input logic [31:0] xm, input logic [31:0] ym,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] rows, input logic [31:0] lim);
    write_reg(CFG_X_MIN, xm);
    write_reg(CFG_Y_MIN, ym);
    write_reg(CFG_STEP_X, sx);
    write_reg(CFG_STEP_Y, sy);
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_MAX_ITER, lim);
    plane_cnt++;
  endtask

  // Valid stays up across back-to-back items; it only drops for a gap.
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
    int gap;
    gap = 0;
    if (idle_pct != 0) begin
      // now and then a long hole so that gaps land on every stage of a pixel
      if ($urandom_range(15) == 0) gap = $urandom_range(1, 2 * int'(max_iter_q) + 24);
      else while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 600) gap = 600;
    end
    time_budget += 2 * longint'(max_iter_q) + 64 + gap;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{pixel_x: col, pixel_y: row};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid, wait for every outstanding result, then let the unit settle.
  // The first edge lets the last accepted item reach the queue.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset plane: corners of the pixel range, rows past the image bottom.
  task automatic test_default_plane();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd512, 12'd512);
    send_pixel(12'd600, 12'd700);
    drain();
  endtask

  // Zero and one iteration limits, zero and one image rows.
  task automatic test_limit_extremes();
    load_plane(Q_NEG2, Q_NEG1, 32'd262144, 32'd262144, 32'd0, 32'd0);
    send_pixel(12'd100, 12'd200);
    send_pixel(12'd0, 12'd0);
    drain();
    load_plane(Q_NEG2, Q_NEG1, 32'd262144, 32'd262144, 32'd1, 32'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    drain();
  endtask

  // c pinned at the edges of the 32-bit range; z saturates on the first step.
  task automatic test_coordinate_saturation();
    load_plane(S32_MAXV, S32_MINV, S32_MAXV, S32_MAXV, 32'd8191, 32'd20);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd2048, 12'd2048);
    drain();
    load_plane(S32_MINV, S32_MAXV, 32'd0, 32'd0, 32'd1, 32'd20);
    send_pixel(12'd1, 12'd1);
    drain();
  endtask

  // Top iteration limit: origin never escapes, c = 2 sits exactly on |z|^2 = 4
  // first, c = 0.26 escapes only after a long orbit.
  task automatic test_long_orbits();
    load_plane(32'd0, 32'd0, 32'd0, 32'd0, 32'd4096, 32'd65535);
    send_pixel(12'd0, 12'd0);
    drain();
    load_plane(2 * Q_ONE, 32'd0, 32'd0, 32'd0, 32'd4096, 32'd65535);
    send_pixel(12'd7, 12'd9);
    drain();
    load_plane(32'd69793218, 32'd0, 32'd0, 32'd0, 32'd4096, 32'd65535);
    send_pixel(12'd3, 12'd5);
    drain();
  endtask

  task automatic random_plane();
    logic [31:0] xm;
    logic [31:0] ym;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] rows;
    logic [31:0] lim;
    if ($urandom_range(7) == 0) begin
      // anywhere at all, mostly saturating
      xm = $urandom;
      ym = $urandom;
      sx = $urandom;
      sy = $urandom;
    end else begin
      // around the set: re in [-2.5, 1.0], im in [-1.5, 1.5]
      xm = $urandom_range(0, 939524096) - 32'd671088640;
      ym = $urandom_range(0, 805306368) - 32'd402653184;
      sx = $urandom_range(1 << 14, 1 << 22);
      sy = $urandom_range(1 << 14, 1 << 22);
    end
    if ($urandom_range(7) == 0) rows = $urandom_range(0, 8191);
    else rows = $urandom_range(1, 4096);
    case ($urandom_range(15))
      0:       lim = $urandom_range(301, 600);
      1, 2, 3: lim = $urandom_range(41, 300);
      default: lim = $urandom_range(1, 40);
    endcase
    load_plane(xm, ym, sx, sy, rows, lim);
  endtask

  // Random planes and pixels under each idling pattern.
  task automatic test_random_planes();
    int          idle_tab[RAND_MODES]  = '{0, 73, 0, 12};
    int          stall_tab[RAND_MODES] = '{0, 0, 73, 12};
    logic [11:0] col;
    logic [11:0] row;
    for (int m = 0; m < RAND_MODES; m++) begin
      idle_pct  = idle_tab[m];
      stall_pct = stall_tab[m];
      for (int p = 0; p < RAND_PLANES; p++) begin
        random_plane();
        for (int n = 0; n < PIX_PER_PLANE; n++) begin
          col = 12'($urandom_range(0, 4095));
          // mostly rows inside the image, the rest anywhere
          if (rows_q != 0 && rows_q <= 4096 && $urandom_range(3) != 0)
            row = 12'($urandom_range(0, int'(rows_q) - 1));
          else
            row = 12'($urandom_range(0, 4095));
          send_pixel(col, row);
        end
        drain();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_plane();
    test_limit_extremes();
    test_coordinate_saturation();
    test_long_orbits();
    test_random_planes();

    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    $display("Summary: %0d pixels in, %0d results checked over %0d plane settings",
             accepted_cnt, checked_cnt, plane_cnt);
    $display("Summary: %0d escaped, %0d ran to the limit, %0d errors",
             escaped_cnt, capped_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
